// File: src/csvs_pkg.sv
package csvs_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd2;

    localparam logic [7:0] RST_DELIMITER = 8'd44;
    localparam logic [7:0] RST_QUALIFIER = 8'd34;
    localparam logic [7:0] RST_ESCAPE    = 8'd92;

    // Bytes at or below this code count as whitespace for trimming.
    localparam logic [7:0] SPACE_MAX = 8'd32;

    // Work list for one request: up to two field bytes, or one field end.
    typedef struct packed {
        logic       b0_v;
        logic [7:0] b0;
        logic       b1_v;
        logic [7:0] b1;
        logic       fend_v;
        logic       fend_lend;
    } csvs_ops_t;

endpackage

// File: src/csvs_ifs.sv
interface csvs_byte_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_char;

    modport source (output valid, output mode, output in_char, input ready);
    modport sink   (input valid, input mode, input in_char, output ready);
endinterface

interface csvs_field_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_field_end;
    logic       line_end;
    logic       overflow;
    logic       last;

    modport source (output valid, output out_char, output is_field_end,
                    output line_end, output overflow, output last, input ready);
    modport sink   (input valid, input out_char, input is_field_end,
                    input line_end, input overflow, input last, output ready);
endinterface

// File: src/csvs_decode.sv
module csvs_decode
    import csvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  mode,
    input  logic [7:0]            in_char,
    output csvs_ops_t             ops
);

    logic [7:0] delim_reg;
    logic [7:0] qual_reg;
    logic [7:0] esc_reg;
    logic       esc_pend_reg;
    logic       esc_pend_next;
    logic       quotes_reg;
    logic       quotes_next;
    logic       is_esc;
    logic       is_qual;
    logic       is_delim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= RST_DELIMITER;
            qual_reg  <= RST_QUALIFIER;
            esc_reg   <= RST_ESCAPE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DELIMITER: delim_reg <= cfg_data;
                REG_QUALIFIER: qual_reg  <= cfg_data;
                REG_ESCAPE:    esc_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign is_esc   = (esc_reg != 8'd0) && (in_char == esc_reg);
    assign is_qual  = (qual_reg != 8'd0) && (in_char == qual_reg);
    assign is_delim = (in_char == delim_reg);

    // Role priority is escape, then qualifier, then delimiter.
    always_comb
    begin
        ops           = '0;
        esc_pend_next = esc_pend_reg;
        quotes_next   = quotes_reg;
        if (mode)
        begin
            ops.fend_v    = 1'b1;
            ops.fend_lend = 1'b1;
            esc_pend_next = 1'b0;
            quotes_next   = 1'b0;
        end
        else if (is_esc)
        begin
            if (esc_pend_reg)
            begin
                ops.b1_v      = 1'b1;
                ops.b1        = esc_reg;
                esc_pend_next = 1'b0;
            end
            else
            begin
                esc_pend_next = 1'b1;
            end
        end
        else if (is_qual)
        begin
            if (esc_pend_reg)
            begin
                ops.b1_v      = 1'b1;
                ops.b1        = qual_reg;
                esc_pend_next = 1'b0;
            end
            else
            begin
                quotes_next = !quotes_reg;
            end
        end
        else if (is_delim)
        begin
            if (esc_pend_reg || quotes_reg)
            begin
                ops.b1_v      = 1'b1;
                ops.b1        = delim_reg;
                esc_pend_next = 1'b0;
            end
            else
            begin
                ops.fend_v    = 1'b1;
                esc_pend_next = 1'b0;
                quotes_next   = 1'b0;
            end
        end
        else
        begin
            if (esc_pend_reg)
            begin
                ops.b0_v      = 1'b1;
                ops.b0        = esc_reg;
                esc_pend_next = 1'b0;
            end
            ops.b1_v = 1'b1;
            ops.b1   = in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pend_reg <= 1'b0;
            quotes_reg   <= 1'b0;
        end
        else if (accept)
        begin
            esc_pend_reg <= esc_pend_next;
            quotes_reg   <= quotes_next;
        end
    end

endmodule

// File: src/csvs_seq.sv
module csvs_seq
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  csvs_ops_t  ops,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_fend,
    output logic       out_lend,
    output logic       out_ovf,
    output logic       out_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BYTE  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    csvs_ops_t        ops_reg;
    csvs_ops_t        ops_next;
    logic             seen_reg;
    logic             seen_next;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;

    logic [7:0]       hold_mem [HOLD_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic             mem_re;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_fend_reg;
    logic             out_lend_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;
    logic             out_load;
    logic [7:0]       load_char;
    logic             load_fend;
    logic             load_lend;
    logic             load_ovf;
    logic             load_last;

    logic             out_free;
    logic [7:0]       cur_ch;
    logic             have_byte;
    logic             more_after;

    assign out_free   = !out_valid_reg || out_ready;
    assign cur_ch     = ops_reg.b0_v ? ops_reg.b0 : ops_reg.b1;
    assign have_byte  = ops_reg.b0_v || ops_reg.b1_v;
    // A byte taken from the first slot still has the second one behind it.
    assign more_after = ops_reg.b0_v && ops_reg.b1_v;
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ops_next    = ops_reg;
        seen_next   = seen_reg;
        held_next   = held_reg;
        ovf_next    = ovf_reg;
        rd_idx_next = rd_idx_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        out_load    = 1'b0;
        load_char   = cur_ch;
        load_fend   = 1'b0;
        load_lend   = 1'b0;
        load_ovf    = 1'b0;
        load_last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ops_next = ops;
                    if (ops.b0_v || ops.b1_v || ops.fend_v)
                        state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                if (have_byte)
                begin
                    if (cur_ch > SPACE_MAX)
                    begin
                        if (rd_idx_reg < held_reg)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_FLUSH;
                        end
                        else if (out_free)
                        begin
                            out_load  = 1'b1;
                            // The second byte makes a result only if it is not space.
                            load_last = !(more_after && (ops_reg.b1 > SPACE_MAX));
                            seen_next   = 1'b1;
                            held_next   = '0;
                            rd_idx_next = '0;
                            if (ops_reg.b0_v)
                                ops_next.b0_v = 1'b0;
                            else
                                ops_next.b1_v = 1'b0;
                            if (!more_after)
                                state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        if (seen_reg)
                        begin
                            if (held_reg < CNT_W'(HOLD_DEPTH))
                            begin
                                mem_we    = 1'b1;
                                held_next = held_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        if (ops_reg.b0_v)
                            ops_next.b0_v = 1'b0;
                        else
                            ops_next.b1_v = 1'b0;
                        if (!more_after)
                            state_next = S_IDLE;
                    end
                end
                else if (ops_reg.fend_v)
                begin
                    if (out_free)
                    begin
                        out_load    = 1'b1;
                        load_char   = 8'd0;
                        load_fend   = 1'b1;
                        load_lend   = ops_reg.fend_lend;
                        load_ovf    = ovf_reg;
                        load_last   = 1'b1;
                        seen_next   = 1'b0;
                        held_next   = '0;
                        ovf_next    = 1'b0;
                        rd_idx_next = '0;
                        ops_next    = '0;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_char   = rd_data_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_BYTE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hold_mem[held_reg[HOLD_AW-1:0]] <= cur_ch;
        if (mem_re)
            rd_data_reg <= hold_mem[rd_idx_reg[HOLD_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ops_reg       <= '0;
            seen_reg      <= 1'b0;
            held_reg      <= '0;
            ovf_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ops_reg    <= ops_next;
            seen_reg   <= seen_next;
            held_reg   <= held_next;
            ovf_reg    <= ovf_next;
            rd_idx_reg <= rd_idx_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= load_char;
            out_fend_reg <= load_fend;
            out_lend_reg <= load_lend;
            out_ovf_reg  <= load_ovf;
            out_last_reg <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_fend  = out_fend_reg;
    assign out_lend  = out_lend_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

endmodule

// File: src/csv_field_splitter.sv
// A taken request is held in the sequencer's ops register; each of its results is
// then loaded into the output register, which can stall. A new request is taken
// only while the sequencer is idle, once its bytes and any held whitespace replayed
// from the hold memory are out; a request with nothing to sequence leaves it idle.
// Reset (rst_n, asynchronous, active low) restores the default delimiter,
// qualifier and escape bytes and clears all field state; no clearing pass.
module csv_field_splitter
    import csvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    csvs_byte_if.sink             byte_stream,
    csvs_field_if.source          field_stream
);

    csvs_ops_t ops;
    logic      accept;

    assign accept = byte_stream.valid && byte_stream.ready;

    csvs_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (byte_stream.mode),
        .in_char   (byte_stream.in_char),
        .ops       (ops)
    );

    csvs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_stream.valid),
        .in_ready  (byte_stream.ready),
        .ops       (ops),
        .out_valid (field_stream.valid),
        .out_ready (field_stream.ready),
        .out_char  (field_stream.out_char),
        .out_fend  (field_stream.is_field_end),
        .out_lend  (field_stream.line_end),
        .out_ovf   (field_stream.overflow),
        .out_last  (field_stream.last)
    );

endmodule
